// ----- rtl/two_class_priority_queue_bank_unit_assert.svh -----
// assertion macros used by the checker file of the priority queue bank
`ifndef TWO_CLASS_PRIORITY_QUEUE_BANK_UNIT_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_BANK_UNIT_ASSERT_SVH

// same-cycle implication, clocked by clk and disabled in reset
`define TCPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcpq assertion failed");

// next-cycle implication, clocked by clk and disabled in reset
`define TCPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcpq assertion failed");

`endif

// ----- rtl/tcpq_pkg.sv -----
// types and constants of the two-class priority queue bank
package tcpq_pkg;

  localparam int NUM_QUEUES  = 20;
  localparam int QUEUE_DEPTH = 5;
  localparam int TAG_WIDTH   = 16;

  // fixed field widths of the request and result
  localparam int QIDX_W      = 5;
  localparam int TAG_IN_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 3;

  localparam int QA_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SLOT_W = TAG_WIDTH + 1;
  localparam int WORD_W = SLOT_W * QUEUE_DEPTH;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic                 urg;
    logic [TAG_WIDTH-1:0] tag;
  } slot_t;

  // what the rebuild unit needs to know about the current request
  typedef struct packed {
    logic                 pop;
    logic                 urgent;
    logic [TAG_WIDTH-1:0] tag;
    logic [CNT_W-1:0]     count;
  } tcpq_cmd_t;

endpackage

// ----- rtl/tcpq_ifs.sv -----
// request and result channel interfaces of the priority queue bank
interface tcpq_in_if import tcpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [QIDX_W-1:0] queue_index;
  logic [TAG_IN_W-1:0] entry_tag;
  logic              urgent;

  modport source (output valid, op, queue_index, entry_tag, urgent, input ready);
  modport sink (input valid, op, queue_index, entry_tag, urgent, output ready);
endinterface

interface tcpq_out_if import tcpq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [TAG_IN_W-1:0]    head_tag;
  logic                   head_urgent;
  logic [COUNT_OUT_W-1:0] count_after;

  modport source (output valid, status, head_tag, head_urgent, count_after, input ready);
  modport sink (input valid, status, head_tag, head_urgent, count_after, output ready);
endinterface

// ----- rtl/tcpq_ram.sv -----
// generic single write port ram with registered read
module tcpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcpq_rebuild.sv -----
// slot-serial rebuild of one queue word for an insert or a pop
module tcpq_rebuild import tcpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [WORD_W-1:0] word_in,
  input  tcpq_cmd_t         cmd,
  output logic [WORD_W-1:0] word_out,
  output logic              done
);

  logic [WORD_W-1:0]        old_w;
  logic [WORD_W-1:0]        new_w;
  slot_t                    prev;
  logic                     found;
  logic                     busy;
  logic [IDX_W-1:0]         step;
  logic [WORD_W+SLOT_W-1:0] old_ext;
  logic [WORD_W+SLOT_W-1:0] new_ext;
  slot_t                    slot0;
  slot_t                    slot1;
  slot_t                    fresh;
  slot_t                    emit;
  logic                     hit;
  logic                     last;

  assign old_ext = {{SLOT_W{1'b0}}, old_w};
  assign slot0   = old_w[SLOT_W-1:0];
  assign slot1   = old_ext[2*SLOT_W-1:SLOT_W];

  assign fresh.urg = cmd.urgent;
  assign fresh.tag = cmd.tag;

  // insertion point: first normal entry for an urgent insert, else the tail
  assign hit  = (CNT_W'(step) == cmd.count) || (cmd.urgent && !slot0.urg);
  assign last = (step == IDX_W'(QUEUE_DEPTH - 1));

  always_comb begin
    if (cmd.pop) begin
      emit = slot1;
    end else if (found) begin
      emit = prev;
    end else if (hit) begin
      emit = fresh;
    end else begin
      emit = slot0;
    end
  end

  assign new_ext  = {emit, new_w};
  assign word_out = new_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy  <= 1'b1;
        found <= 1'b0;
        step  <= '0;
      end else if (busy) begin
        if (hit) begin
          found <= 1'b1;
        end
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // old word drains from slot 0, new word fills from the top
  always_ff @(posedge clk) begin
    if (load) begin
      old_w <= word_in;
    end else if (busy) begin
      old_w <= old_ext[WORD_W+SLOT_W-1:SLOT_W];
      new_w <= new_ext[WORD_W+SLOT_W-1:SLOT_W];
      prev  <= slot0;
    end
  end

endmodule

// ----- rtl/two_class_priority_queue_bank_unit.sv -----
// an accepted insert or pop that changes a queue has its word read from the ram, rebuilt
// one slot per cycle and written back as its result is registered
// a rejected request (full, empty or invalid index) skips the read and rebuild and goes to its result
// one request is in work at a time; the next is taken once the result is registered
// rst is synchronous: all queue counts clear, queue word storage is left as it is
module two_class_priority_queue_bank_unit import tcpq_pkg::*; (
  input logic         clk,
  input logic         rst,
  tcpq_in_if.sink     req,
  tcpq_out_if.source  rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_STEP = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]  counts [NUM_QUEUES];

  logic              accept;
  logic              q_ok;
  logic [QA_W-1:0]   rd_qaddr;
  logic [CNT_W-1:0]  cur_cnt;
  logic              is_pop;
  logic              is_full;
  logic              is_empty;
  logic              go_rebuild;
  logic              fire;

  // per-request registers
  logic [QA_W-1:0]   qaddr;
  logic              do_write;
  status_t           res_status;
  logic [CNT_W-1:0]  res_cnt;
  slot_t             head;
  tcpq_cmd_t         cmd;

  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] rb_word;
  logic              rb_done;
  slot_t             rd_head;

  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  logic                   out_valid;
  status_t                out_status;
  logic [TAG_IN_W-1:0]    out_tag;
  logic                   out_urg;
  logic [COUNT_OUT_W-1:0] out_cnt;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign q_ok     = ({1'b0, req.queue_index} < (QIDX_W + 1)'(NUM_QUEUES));
  assign rd_qaddr = req.queue_index[QA_W-1:0];
  assign cur_cnt  = q_ok ? counts[rd_qaddr] : '0;
  assign is_pop   = (req.op == OP_POP);
  assign is_full  = (cur_cnt == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (cur_cnt == '0);
  assign go_rebuild = q_ok && !(is_pop ? is_empty : is_full);

  assign fire    = (state == S_DONE) && (!out_valid || rsp.ready);
  assign rd_head = ram_rdata[SLOT_W-1:0];
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, res_cnt};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = go_rebuild ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        if (rb_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
        if (do_write) begin
          counts[qaddr] <= res_cnt;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and outcome
  always_ff @(posedge clk) begin
    if (accept) begin
      qaddr      <= rd_qaddr;
      do_write   <= go_rebuild;
      head       <= '0;
      cmd.pop    <= is_pop;
      cmd.urgent <= req.urgent;
      cmd.tag    <= TAG_WIDTH'(req.entry_tag);
      cmd.count  <= cur_cnt;
      if (!q_ok) begin
        res_status <= ST_INVALID;
        res_cnt    <= '0;
      end else if (is_pop && is_empty) begin
        res_status <= ST_EMPTY;
        res_cnt    <= '0;
      end else if (!is_pop && is_full) begin
        res_status <= ST_FULL;
        res_cnt    <= cur_cnt;
      end else begin
        res_status <= ST_OK;
        res_cnt    <= is_pop ? (cur_cnt - 1'b1) : (cur_cnt + 1'b1);
      end
    end else if ((state == S_LOAD) && cmd.pop) begin
      head <= rd_head;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= res_status;
      out_tag    <= TAG_IN_W'(head.tag);
      out_urg    <= head.urg;
      out_cnt    <= cnt_ext[COUNT_OUT_W-1:0];
    end
  end

  tcpq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_QUEUES)
  ) u_ram (
    .clk   (clk),
    .we    (fire && do_write),
    .waddr (qaddr),
    .wdata (rb_word),
    .re    (accept && go_rebuild),
    .raddr (rd_qaddr),
    .rdata (ram_rdata)
  );

  tcpq_rebuild u_rebuild (
    .clk      (clk),
    .rst      (rst),
    .load     (state == S_LOAD),
    .word_in  (ram_rdata),
    .cmd      (cmd),
    .word_out (rb_word),
    .done     (rb_done)
  );

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.head_tag    = out_tag;
  assign rsp.head_urgent = out_urg;
  assign rsp.count_after = out_cnt;

endmodule

// ----- rtl/tcpq_checker.sv -----
// port-level checks of the priority queue bank and their binding
`include "two_class_priority_queue_bank_unit_assert.svh"

module tcpq_checker import tcpq_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [TAG_IN_W-1:0]    head_tag,
  input logic                   head_urgent,
  input logic [COUNT_OUT_W-1:0] count_after
);

  // a stalled result holds
  `TCPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(status) && $stable(head_tag) && $stable(head_urgent)
    && $stable(count_after))

  // one request in work at a time
  `TCPQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

  // a rejected request returns no entry
  `TCPQ_ASSERT_NOW(a_no_head_on_reject, rsp_valid && (status != ST_OK),
    (head_tag == '0) && !head_urgent)

  // an empty queue or a bad index reports no entries
  `TCPQ_ASSERT_NOW(a_zero_count, rsp_valid && ((status == ST_EMPTY) || (status == ST_INVALID)),
    count_after == '0)

endmodule

bind two_class_priority_queue_bank_unit tcpq_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .head_tag    (rsp.head_tag),
  .head_urgent (rsp.head_urgent),
  .count_after (rsp.count_after)
);

// ----- tb/two_class_priority_queue_bank_unit_tb.sv -----
// self-checking testbench of the two-class priority queue bank
`timescale 1ns / 100ps

module two_class_priority_queue_bank_unit_tb import tcpq_pkg::*; ();

  typedef struct packed {
    status_t                status;
    logic [TAG_IN_W-1:0]    head_tag;
    logic                   head_urgent;
    logic [COUNT_OUT_W-1:0] count_after;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  tcpq_in_if  req_if ();
  tcpq_out_if rsp_if ();

  two_class_priority_queue_bank_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the bank
  slot_t shadow_slots [NUM_QUEUES][QUEUE_DEPTH];
  int    shadow_fill  [NUM_QUEUES];

  queue_result_t awaited_results [$];
  int            mismatches       = 0;
  bit            source_idle_on   = 1'b1;
  bit            sink_idle_on     = 1'b1;
  int            sink_hold_cycles = 0;

  function automatic queue_result_t predict_queue_op(op_t op, logic [QIDX_W-1:0] qidx,
                                                     logic [TAG_IN_W-1:0] tag, logic urg);
    queue_result_t res;
    slot_t         entry;
    int            n;
    int            pos;
    res.status      = ST_OK;
    res.head_tag    = '0;
    res.head_urgent = 1'b0;
    res.count_after = '0;
    if (qidx >= NUM_QUEUES) begin
      res.status = ST_INVALID;
      return res;
    end
    n = shadow_fill[qidx];
    if (op == OP_INSERT) begin
      if (n >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = n;
        // urgent entries go behind the last urgent one already queued
        if (urg) begin
          pos = 0;
          while (pos < n && shadow_slots[qidx][pos].urg) pos++;
        end
        for (int i = n; i > pos; i--) shadow_slots[qidx][i] = shadow_slots[qidx][i-1];
        entry.urg = urg;
        entry.tag = TAG_WIDTH'(tag);
        shadow_slots[qidx][pos] = entry;
        n++;
      end
    end else if (n == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.head_tag    = TAG_IN_W'(shadow_slots[qidx][0].tag);
      res.head_urgent = shadow_slots[qidx][0].urg;
      for (int i = 1; i < n; i++) shadow_slots[qidx][i-1] = shadow_slots[qidx][i];
      n--;
    end
    shadow_fill[qidx] = n;
    res.count_after = COUNT_OUT_W'(n);
    return res;
  endfunction

  // called at a rising edge; valid stays high on return
  task automatic send_request(op_t op, logic [QIDX_W-1:0] qidx,
                              logic [TAG_IN_W-1:0] tag, logic urg);
    int gap;
    gap = source_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.queue_index <= qidx;
    req_if.entry_tag   <= tag;
    req_if.urgent      <= urg;
    do @(posedge clk); while (!req_if.ready);
    awaited_results.push_back(predict_queue_op(op, qidx, tag, urg));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    queue_result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with no request outstanding, expected none, actual status %0d",
               $time, rsp_if.status);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", want.status, rsp_if.status);
    compare_field("head_tag", want.head_tag, rsp_if.head_tag);
    compare_field("head_urgent", want.head_urgent, rsp_if.head_urgent);
    compare_field("count_after", want.count_after, rsp_if.count_after);
  endfunction

  // result side: random stalls, long hold-offs on demand, checks every result
  initial begin : result_sink
    int gap;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = sink_idle_on ? $urandom_range(0, 5) : 0;
      forever begin
        if (sink_hold_cycles > 0) begin
          rsp_if.ready <= 1'b0;
          sink_hold_cycles--;
        end else if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          gap--;
        end else begin
          rsp_if.ready <= 1'b1;
        end
        @(posedge clk);
        if (rsp_if.valid && rsp_if.ready) break;
      end
      check_result();
    end
  end

  task automatic test_directed_cases();
    // empty pop, both classes, urgent order, full queue, drain to empty
    send_request(OP_POP,    5'd0, 16'h0000, 1'b0);
    send_request(OP_INSERT, 5'd0, 16'h0000, 1'b0);
    send_request(OP_INSERT, 5'd0, 16'hffff, 1'b0);
    send_request(OP_INSERT, 5'd0, 16'h1234, 1'b1);
    send_request(OP_INSERT, 5'd0, 16'h5678, 1'b1);
    send_request(OP_INSERT, 5'd0, 16'haaaa, 1'b0);
    send_request(OP_INSERT, 5'd0, 16'h5555, 1'b1);
    repeat (QUEUE_DEPTH + 1) send_request(OP_POP, 5'd0, 16'hffff, 1'b1);
    // last valid queue, pop fields ignored
    send_request(OP_INSERT, 5'(NUM_QUEUES - 1), 16'hffff, 1'b1);
    send_request(OP_INSERT, 5'(NUM_QUEUES - 1), 16'h8001, 1'b1);
    send_request(OP_POP,    5'(NUM_QUEUES - 1), 16'h7777, 1'b1);
    send_request(OP_POP,    5'(NUM_QUEUES - 1), 16'h0000, 1'b0);
    // out of range indexes leave everything untouched
    send_request(OP_INSERT, 5'(NUM_QUEUES), 16'hbeef, 1'b0);
    send_request(OP_POP,    5'd31, 16'h0000, 1'b0);
    send_request(OP_INSERT, 5'd31, 16'hffff, 1'b1);
    send_request(OP_POP,    5'(NUM_QUEUES - 1), 16'h0000, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_output_stall();
    source_idle_on   = 1'b0;
    sink_hold_cycles = 150;
    for (int i = 0; i < 30; i++)
      send_request(($urandom_range(0, 2) != 0) ? OP_INSERT : OP_POP,
                   5'($urandom_range(2, 4)), 16'($urandom), 1'($urandom_range(0, 1)));
    wait_results_drained();
    source_idle_on = 1'b1;
  endtask

  task automatic test_pause_and_resume();
    for (int i = 0; i < 24; i++) begin
      send_request(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_POP,
                   5'($urandom_range(5, 6)), 16'($urandom), 1'($urandom_range(0, 1)));
      if (i == 11) wait_results_drained();
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int                  insert_pct;
    int                  urgent_pct;
    int                  base;
    int                  span;
    int                  pick;
    logic [QIDX_W-1:0]   qidx;
    for (int seg = 0; seg < 14; seg++) begin
      source_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on   = ($urandom_range(0, 3) != 0);
      insert_pct     = $urandom_range(35, 65);
      urgent_pct     = $urandom_range(10, 90);
      base           = $urandom_range(0, NUM_QUEUES - 1);
      span           = $urandom_range(1, 4);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        // a few bad indexes, a few scattered requests, the rest on a small set of queues
        if (pick < 6 && NUM_QUEUES < 32)
          qidx = QIDX_W'($urandom_range(NUM_QUEUES, 31));
        else if (pick < 20)
          qidx = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
        else
          qidx = QIDX_W'((base + $urandom_range(0, span - 1)) % NUM_QUEUES);
        send_request(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP, qidx,
                     16'($urandom), ($urandom_range(0, 99) < urgent_pct));
      end
    end
    source_idle_on = 1'b1;
    sink_idle_on   = 1'b1;
    wait_results_drained();
  endtask

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_INSERT;
    req_if.queue_index <= '0;
    req_if.entry_tag   <= '0;
    req_if.urgent      <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_stall();
    test_pause_and_resume();
    test_random_traffic();
    // catch any stray result after the last one
    repeat (QUEUE_DEPTH + 12) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("two_class_priority_queue_bank_unit regression: pass");
    end else begin
      $display("two_class_priority_queue_bank_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timed out with %0d results outstanding", $time, awaited_results.size());
    $display("two_class_priority_queue_bank_unit regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tcpq_pkg.sv
rtl/tcpq_ifs.sv
rtl/tcpq_ram.sv
rtl/tcpq_rebuild.sv
rtl/two_class_priority_queue_bank_unit.sv
rtl/tcpq_checker.sv
tb/two_class_priority_queue_bank_unit_tb.sv
